// ----- rtl/splay_tree_prefix_coder_core_assert.svh -----
// assertion macros for the splay tree prefix coder
`ifndef SPLAY_TREE_PREFIX_CODER_CORE_ASSERT_SVH
`define SPLAY_TREE_PREFIX_CODER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define STC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define STC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/stc_pkg.sv -----
`timescale 1ns / 1ps

package stc_pkg;

  localparam int ALPHABET = 256;
  localparam int NODES    = 2 * ALPHABET + 1;
  localparam int NODE_W   = $clog2(NODES);
  localparam int INT_W    = $clog2(ALPHABET);
  localparam int SYM_W    = 9;

  // input command codes
  localparam logic CMD_DATA   = 1'b0;
  localparam logic CMD_NEW    = 1'b1;
  // mode codes
  localparam logic MODE_ENC   = 1'b0;
  localparam logic MODE_DEC   = 1'b1;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_IDLE,
    ST_E_RDP,
    ST_E_RDR,
    ST_E_PUSH,
    ST_E_POPRD,
    ST_E_POPBIT,
    ST_E_END,
    ST_SP_RDA,
    ST_SP_RDC,
    ST_SP_RDD,
    ST_SP_WR1,
    ST_SP_WR2,
    ST_D_RD,
    ST_D_NODE,
    ST_D_NEXT,
    ST_D_FIN
  } state_t;

endpackage

// ----- rtl/stc_ram.sv -----
`timescale 1ns / 1ps

module stc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/splay_tree_prefix_coder_core.sv -----
// encode climbs the path from the symbol's leaf to the root one level at a time,
//   then packs the path bits into bytes, then semi-splays the leaf two levels per
//   step; decode walks one input bit at a time plus the semi-splay of each leaf
//   reached. each tree memory has one write and one read port. one transaction is
//   handled at a time; deep paths take longer, and output stalls hold the flow.
// reset (and every new-stream command) runs a pass rebuilding the balanced tree
//   in memory; no input is taken during that pass.
`timescale 1ns / 1ps
`include "splay_tree_prefix_coder_core_assert.svh"

module splay_tree_prefix_coder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,   // mode
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,     // value [8:0], zero above
  input  logic        s_tuser,     // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,     // value_res [8:0], zero above
  output logic        m_tlast,     // last
  output logic        m_tuser      // stream_end
);
  import stc_pkg::*;

  state_t state, state_next;

  logic              mode;
  logic              ended;
  logic [NODE_W-1:0] clr_cnt;
  logic [7:0]        bit_buf;
  logic [2:0]        bit_pos;
  logic [INT_W-1:0]  walk;
  logic [NODE_W-1:0] node_a;
  logic [INT_W-1:0]  node_u;
  logic [INT_W-1:0]  node_d;
  logic [NODE_W-1:0] lcc;
  logic [NODE_W-1:0] b_node;
  logic [INT_W:0]    sp;
  logic [SYM_W-1:0]  sym_v;
  logic              is_end;
  logic [7:0]        dbyte;
  logic [2:0]        dbit;
  logic              hold_valid;
  logic [SYM_W-1:0]  hold_val;
  logic              hold_se;

  // memory ports
  logic              par_we, par_re;
  logic [NODE_W-1:0] par_waddr, par_raddr;
  logic [INT_W-1:0]  par_wdata, par_rd;
  logic              lft_we, lft_re, rgt_we, rgt_re;
  logic [INT_W-1:0]  lft_waddr, lft_raddr, rgt_waddr, rgt_raddr;
  logic [NODE_W-1:0] lft_wdata, rgt_wdata, lft_rd, rgt_rd;
  logic              stk_we, stk_re, stk_wdata, stk_rd;
  logic [INT_W-1:0]  stk_waddr, stk_raddr;

  // result push into the output register
  logic              push;
  logic [SYM_W-1:0]  push_val;
  logic              push_last, push_se;

  logic              in_acc;
  logic              out_free;
  logic [SYM_W-1:0]  in_val;
  logic              dec_bit;
  logic [NODE_W-1:0] dec_node;
  logic              dec_leaf;
  logic [7:0]        pack_byte;
  logic              c_is_left;
  logic              enc_ok;

  assign s_tready  = (state == ST_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign in_val    = s_tdata[SYM_W-1:0];
  assign dec_bit   = dbyte[dbit];
  assign dec_node  = dec_bit ? rgt_rd : lft_rd;
  assign dec_leaf  = (dec_node >= NODE_W'(ALPHABET));
  assign pack_byte = bit_buf | (8'(stk_rd) << bit_pos);
  assign c_is_left = ({{(NODE_W-INT_W){1'b0}}, node_u} == lft_rd);
  assign enc_ok    = (in_val <= SYM_W'(ALPHABET));

  stc_ram #(.WIDTH(INT_W), .DEPTH(NODES)) u_parent (
    .clk, .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .re(par_re), .raddr(par_raddr), .rdata(par_rd)
  );
  stc_ram #(.WIDTH(NODE_W), .DEPTH(ALPHABET)) u_left (
    .clk, .we(lft_we), .waddr(lft_waddr), .wdata(lft_wdata),
    .re(lft_re), .raddr(lft_raddr), .rdata(lft_rd)
  );
  stc_ram #(.WIDTH(NODE_W), .DEPTH(ALPHABET)) u_right (
    .clk, .we(rgt_we), .waddr(rgt_waddr), .wdata(rgt_wdata),
    .re(rgt_re), .raddr(rgt_raddr), .rdata(rgt_rd)
  );
  stc_ram #(.WIDTH(1), .DEPTH(ALPHABET)) u_path (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .re(stk_re), .raddr(stk_raddr), .rdata(stk_rd)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLR: begin
        if (clr_cnt == NODE_W'(NODES - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (s_tuser == CMD_NEW) state_next = ST_CLR;
          else if (ended) state_next = ST_IDLE;
          else if (mode == MODE_DEC) state_next = ST_D_RD;
          else if (enc_ok) state_next = ST_E_RDP;
        end
      end
      ST_E_RDP:  state_next = ST_E_RDR;
      ST_E_RDR:  state_next = ST_E_PUSH;
      ST_E_PUSH: state_next = (node_u == '0) ? ST_E_POPRD : ST_E_RDP;
      ST_E_POPRD: state_next = (sp == '0) ? ST_SP_RDA : ST_E_POPBIT;
      ST_E_POPBIT: begin
        if (bit_pos != 3'd7 || out_free) state_next = ST_E_POPRD;
      end
      ST_E_END: begin
        if (!is_end || bit_pos == 3'd0 || out_free) state_next = ST_IDLE;
      end
      ST_SP_RDA: state_next = ST_SP_RDC;
      ST_SP_RDC: begin
        if (par_rd == '0) state_next = (mode == MODE_ENC) ? ST_E_END : ST_D_NEXT;
        else state_next = ST_SP_RDD;
      end
      ST_SP_RDD: state_next = ST_SP_WR1;
      ST_SP_WR1: state_next = ST_SP_WR2;
      ST_SP_WR2: begin
        if (node_d == '0) state_next = (mode == MODE_ENC) ? ST_E_END : ST_D_NEXT;
        else state_next = ST_SP_RDA;
      end
      ST_D_RD: state_next = ST_D_NODE;
      ST_D_NODE: begin
        if (!dec_leaf) state_next = ST_D_NEXT;
        else if (!hold_valid || out_free) state_next = ST_SP_RDA;
      end
      ST_D_NEXT: begin
        if ((hold_valid && hold_se) || dbit == 3'd7) state_next = ST_D_FIN;
        else state_next = ST_D_RD;
      end
      ST_D_FIN: begin
        if (!hold_valid || out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory controls and result push
  always_comb begin
    par_we = 1'b0; par_waddr = '0; par_wdata = '0; par_re = 1'b0; par_raddr = '0;
    lft_we = 1'b0; lft_waddr = '0; lft_wdata = '0; lft_re = 1'b0; lft_raddr = '0;
    rgt_we = 1'b0; rgt_waddr = '0; rgt_wdata = '0; rgt_re = 1'b0; rgt_raddr = '0;
    stk_we = 1'b0; stk_waddr = '0; stk_wdata = 1'b0; stk_re = 1'b0; stk_raddr = '0;
    push = 1'b0; push_val = '0; push_last = 1'b0; push_se = 1'b0;
    unique case (state)
      ST_CLR: begin
        par_we    = 1'b1;
        par_waddr = clr_cnt;
        par_wdata = (clr_cnt == '0) ? '0 : INT_W'((clr_cnt - 1'b1) >> 1);
        if (clr_cnt < NODE_W'(ALPHABET)) begin
          lft_we    = 1'b1;
          lft_waddr = clr_cnt[INT_W-1:0];
          lft_wdata = {clr_cnt[NODE_W-2:0], 1'b1};
          rgt_we    = 1'b1;
          rgt_waddr = clr_cnt[INT_W-1:0];
          rgt_wdata = {clr_cnt[NODE_W-2:0], 1'b0} + NODE_W'(2);
        end
      end
      ST_E_RDP: begin
        par_re = 1'b1; par_raddr = node_a;
      end
      ST_E_RDR: begin
        rgt_re = 1'b1; rgt_raddr = par_rd;
      end
      ST_E_PUSH: begin
        stk_we = 1'b1; stk_waddr = sp[INT_W-1:0]; stk_wdata = (rgt_rd == node_a);
      end
      ST_E_POPRD: begin
        if (sp != '0) begin
          stk_re = 1'b1; stk_raddr = INT_W'(sp - 1'b1);
        end
      end
      ST_E_POPBIT: begin
        // last unless a further full byte or an end flush still follows
        if (bit_pos == 3'd7 && out_free) begin
          push = 1'b1; push_val = SYM_W'(pack_byte);
          push_last = (sp < (INT_W+1)'(8)) && !(is_end && sp != '0);
          push_se = is_end;
        end
      end
      ST_E_END: begin
        if (is_end && bit_pos != 3'd0 && out_free) begin
          push = 1'b1; push_val = SYM_W'(bit_buf); push_last = 1'b1; push_se = 1'b1;
        end
      end
      ST_SP_RDA: begin
        par_re = 1'b1; par_raddr = node_a;
      end
      ST_SP_RDC: begin
        if (par_rd != '0) begin
          par_re = 1'b1; par_raddr = NODE_W'(par_rd);
          lft_re = 1'b1; lft_raddr = par_rd;
        end
      end
      ST_SP_RDD: begin
        lft_re = 1'b1; lft_raddr = par_rd;
        rgt_re = 1'b1; rgt_raddr = par_rd;
      end
      ST_SP_WR1: begin
        if (c_is_left) begin
          rgt_we = 1'b1; rgt_waddr = node_d; rgt_wdata = node_a;
        end else begin
          lft_we = 1'b1; lft_waddr = node_d; lft_wdata = node_a;
        end
        par_we = 1'b1; par_waddr = node_a; par_wdata = node_d;
      end
      ST_SP_WR2: begin
        if (node_a == lcc) begin
          lft_we = 1'b1; lft_waddr = node_u; lft_wdata = b_node;
        end else begin
          rgt_we = 1'b1; rgt_waddr = node_u; rgt_wdata = b_node;
        end
        par_we = 1'b1; par_waddr = b_node; par_wdata = node_u;
      end
      ST_D_RD: begin
        if (dec_bit) begin
          rgt_re = 1'b1; rgt_raddr = walk;
        end else begin
          lft_re = 1'b1; lft_raddr = walk;
        end
      end
      ST_D_NODE: begin
        if (dec_leaf && hold_valid && out_free) begin
          push = 1'b1; push_val = hold_val; push_last = 1'b0; push_se = hold_se;
        end
      end
      ST_D_FIN: begin
        if (hold_valid && out_free) begin
          push = 1'b1; push_val = hold_val; push_last = 1'b1; push_se = hold_se;
        end
      end
      default: ;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLR;
      mode       <= MODE_ENC;
      ended      <= 1'b0;
      clr_cnt    <= '0;
      bit_buf    <= '0;
      bit_pos    <= '0;
      walk       <= '0;
      hold_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) mode <= cfg_wdata;

      // output register
      if (push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_CLR: clr_cnt <= clr_cnt + 1'b1;
        ST_IDLE: begin
          if (in_acc && s_tuser == CMD_NEW) begin
            clr_cnt <= '0;
            bit_buf <= '0;
            bit_pos <= '0;
            walk    <= '0;
            ended   <= 1'b0;
          end
        end
        ST_E_POPBIT: begin
          if (bit_pos != 3'd7) begin
            bit_buf <= pack_byte;
            bit_pos <= bit_pos + 1'b1;
          end else if (out_free) begin
            bit_buf <= '0;
            bit_pos <= '0;
          end
        end
        ST_E_END: begin
          if (is_end && (bit_pos == 3'd0 || out_free)) begin
            bit_buf <= '0;
            bit_pos <= '0;
            ended   <= 1'b1;
          end
        end
        ST_D_NODE: begin
          if (!dec_leaf) begin
            walk <= dec_node[INT_W-1:0];
          end else if (!hold_valid || out_free) begin
            walk       <= '0;
            hold_valid <= 1'b1;
          end
        end
        ST_D_NEXT: begin
          if (hold_valid && hold_se) ended <= 1'b1;
        end
        ST_D_FIN: begin
          if (out_free) hold_valid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (push) begin
      m_tdata <= {{(16-SYM_W){1'b0}}, push_val};
      m_tlast <= push_last;
      m_tuser <= push_se;
    end
    case (state)
      ST_IDLE: begin
        node_a <= NODE_W'(in_val) + NODE_W'(ALPHABET);
        sym_v  <= in_val;
        is_end <= (in_val == SYM_W'(ALPHABET));
        sp     <= '0;
        dbyte  <= in_val[7:0];
        dbit   <= '0;
      end
      ST_E_RDR: node_u <= par_rd;
      ST_E_PUSH: begin
        sp     <= sp + 1'b1;
        node_a <= NODE_W'(node_u);
      end
      ST_E_POPRD: begin
        if (sp == '0) node_a <= NODE_W'(sym_v) + NODE_W'(ALPHABET);
        else sp <= sp - 1'b1;
      end
      ST_SP_RDC: node_u <= par_rd;
      ST_SP_RDD: begin
        node_d <= par_rd;
        lcc    <= lft_rd;
      end
      ST_SP_WR1: b_node <= c_is_left ? rgt_rd : lft_rd;
      ST_SP_WR2: node_a <= NODE_W'(node_d);
      ST_D_NODE: begin
        if (dec_leaf && (!hold_valid || out_free)) begin
          hold_val <= SYM_W'(dec_node - NODE_W'(ALPHABET));
          hold_se  <= (dec_node == NODE_W'(NODES - 1));
          node_a   <= dec_node;
        end
      end
      ST_D_NEXT: dbit <= dbit + 1'b1;
      default: ;
    endcase
  end

  // checks
  `STC_ASSERT_NOW(a_idle_no_hold, state == ST_IDLE, !hold_valid, "held result left at idle")
  `STC_ASSERT_NEXT(a_out_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped while stalled")
  `STC_ASSERT_NEXT(a_cmd_clears, in_acc && s_tuser == CMD_NEW, state == ST_CLR && !ended, "new stream not rebuilt")

endmodule
